[design/bsa_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsa_pkg
// Shared types, codes and defaults of the bitmap slot allocator.
// ---------------------------------------------------------------------------
package bsa_pkg;

	localparam int DEF_MAP_WORDS = 128;
	localparam int DEF_WORD_BITS = 32;

	localparam int IDX_W      = 12;
	localparam int CNT_W      = 13;
	localparam int SIZE_W     = 17;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_READ_ONLY       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INODE_COUNT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZONE_COUNT      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_DATA_ZONE = 2'd3;

	localparam logic        RST_READ_ONLY       = 1'b0;
	localparam logic [11:0] RST_INODE_COUNT     = 12'd4095;
	localparam logic [15:0] RST_ZONE_COUNT      = 16'd4100;
	localparam logic [15:0] RST_FIRST_DATA_ZONE = 16'd5;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_FREE_ERR = 2'd2,
		ST_RO       = 2'd3
	} status_t;

	typedef struct packed {
		logic        read_only;
		logic [11:0] inode_count;
		logic [15:0] zone_count;
		logic [15:0] first_data_zone;
	} cfg_t;

	typedef struct packed {
		logic has_clear;
		logic in_range;
	} word_stat_t;

endpackage

[design/bitmap_slot_allocator.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bitmap_slot_allocator
// Next-fit allocator over an inode bitmap and a zone bitmap with a zone use count.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  request  | in_valid / in_stall  | req_type, map_select, bit_index
//  result   | out_valid/ out_stall | status, bit_number, zones_in_use
//  config   | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// A read-only refusal goes from acceptance straight to the result; a free passes
// prepare, route, read and check (the last two skipped when the bit lies outside
// the store); an allocate passes prepare and route, then scans at most MAP_WORDS
// words. The scan rate is set by the bitmap memory read port, one word per cycle.
// After reset a clearing pass over all 2**(WA+1) words zeroes both maps; requests are
// stalled meanwhile while configuration writes proceed.
// The next request is accepted while a finished result still waits on out_stall.
module bitmap_slot_allocator
	import bsa_pkg::*;
#(
	parameter int MAP_WORDS = DEF_MAP_WORDS,
	parameter int WORD_BITS = DEF_WORD_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic                  map_select,
	input  logic [IDX_W-1:0]      bit_index,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            status,
	output logic [IDX_W-1:0]      bit_number,
	output logic [CNT_W-1:0]      zones_in_use,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WA   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BN_W = $clog2(MAP_WORDS * WORD_BITS);
	localparam int CW   = (BN_W + 1 > SIZE_W) ? BN_W + 1 : SIZE_W;

	cfg_t                 cfg_q;
	logic                 ram_we;
	logic [WA:0]          ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic [WA:0]          ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;
	logic [BN_W-1:0]      scan_base;
	logic [CW-1:0]        scan_limit;
	word_stat_t           ws;
	logic [BN_W-1:0]      ws_bit;
	logic [WORD_BITS-1:0] ws_word;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.read_only       <= RST_READ_ONLY;
			cfg_q.inode_count     <= RST_INODE_COUNT;
			cfg_q.zone_count      <= RST_ZONE_COUNT;
			cfg_q.first_data_zone <= RST_FIRST_DATA_ZONE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_READ_ONLY:       cfg_q.read_only       <= cfg_data[0];
				REG_INODE_COUNT:     cfg_q.inode_count     <= cfg_data[11:0];
				REG_ZONE_COUNT:      cfg_q.zone_count      <= cfg_data;
				REG_FIRST_DATA_ZONE: cfg_q.first_data_zone <= cfg_data;
				default:             cfg_q.read_only       <= cfg_q.read_only;
			endcase
		end
	end

	bsa_ctrl #(
		.MAP_WORDS (MAP_WORDS),
		.WORD_BITS (WORD_BITS),
		.WA        (WA),
		.BN_W      (BN_W),
		.CW        (CW)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.map_select   (map_select),
		.bit_index    (bit_index),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.bit_number   (bit_number),
		.zones_in_use (zones_in_use),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.scan_base    (scan_base),
		.scan_limit   (scan_limit),
		.ws           (ws),
		.ws_bit       (ws_bit),
		.ws_word      (ws_word)
	);

	bsa_bitmap_ram #(
		.WORD_BITS (WORD_BITS),
		.ADDR_W    (WA + 1)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bsa_word_unit #(
		.WORD_BITS (WORD_BITS),
		.BN_W      (BN_W),
		.CW        (CW)
	) u_word (
		.word     (ram_rdata),
		.base     (scan_base),
		.limit    (scan_limit),
		.stat     (ws),
		.bit_num  (ws_bit),
		.set_word (ws_word)
	);

endmodule

[design/bsa_bitmap_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsa_bitmap_ram
// Bitmap word store with one write port and one registered read port.
// ---------------------------------------------------------------------------
module bsa_bitmap_ram #(
	parameter int WORD_BITS = 32,
	parameter int ADDR_W    = 8
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic [ADDR_W-1:0]    raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[design/bsa_word_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsa_word_unit
// Finds the lowest clear bit of one bitmap word and checks it against the map size.
// ---------------------------------------------------------------------------
module bsa_word_unit
	import bsa_pkg::*;
#(
	parameter int WORD_BITS = 32,
	parameter int BN_W      = 12,
	parameter int CW        = 17
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [BN_W-1:0]      base,
	input  logic [CW-1:0]        limit,
	output word_stat_t           stat,
	output logic [BN_W-1:0]      bit_num,
	output logic [WORD_BITS-1:0] set_word
);

	localparam int BI_W = $clog2(WORD_BITS);

	logic [BI_W-1:0] lc;

	always_comb begin
		lc = '0;
		for (int k = WORD_BITS - 1; k >= 0; k--) begin
			if (!word[k]) begin
				lc = BI_W'(k);
			end
		end
	end

	assign bit_num        = base + BN_W'(lc);
	assign stat.has_clear = ~&word;
	assign stat.in_range  = CW'(bit_num) < limit;
	assign set_word       = word | (WORD_BITS'(1) << lc);

endmodule

[design/bsa_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsa_ctrl
// Request sequencer: start-word split, circular word scan, free check and result register.
// ---------------------------------------------------------------------------
module bsa_ctrl
	import bsa_pkg::*;
#(
	parameter int MAP_WORDS = 128,
	parameter int WORD_BITS = 32,
	parameter int WA        = 7,
	parameter int BN_W      = 12,
	parameter int CW        = 17
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic                 map_select,
	input  logic [IDX_W-1:0]     bit_index,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           status,
	output logic [IDX_W-1:0]     bit_number,
	output logic [CNT_W-1:0]     zones_in_use,
	output logic                 ram_we,
	output logic [WA:0]          ram_waddr,
	output logic [WORD_BITS-1:0] ram_wdata,
	output logic [WA:0]          ram_raddr,
	input  logic [WORD_BITS-1:0] ram_rdata,
	output logic [BN_W-1:0]      scan_base,
	output logic [CW-1:0]        scan_limit,
	input  word_stat_t           ws,
	input  logic [BN_W-1:0]      ws_bit,
	input  logic [WORD_BITS-1:0] ws_word
);

	localparam int BI_W   = $clog2(WORD_BITS);
	localparam int XW     = (BN_W > IDX_W) ? BN_W : IDX_W;
	localparam int ICNT_W = $clog2(MAP_WORDS + 1);
	localparam logic [CW-1:0]     STORE_BITS = CW'(MAP_WORDS * WORD_BITS);
	localparam logic [ICNT_W-1:0] ICNT_END   = ICNT_W'(MAP_WORDS);
	localparam logic [WA-1:0]     LAST_WORD  = WA'(MAP_WORDS - 1);
	localparam logic [IDX_W:0]    MW_L       = (IDX_W + 1)'(MAP_WORDS);

	typedef enum logic [7:0] {
		S_CLEAR    = 8'b00000001,
		S_IDLE     = 8'b00000010,
		S_PREP     = 8'b00000100,
		S_ROUTE    = 8'b00001000,
		S_SCAN     = 8'b00010000,
		S_FREE_RD  = 8'b00100000,
		S_FREE_CHK = 8'b01000000,
		S_DONE     = 8'b10000000
	} state_t;

	state_t              state_q;
	logic [WA:0]         clr_q;
	logic [ICNT_W-1:0]   icnt_q;
	logic                cv_s1;
	logic                out_valid_q;
	logic [CNT_W-1:0]    zcnt_q;

	logic                req_q;
	logic                sel_q;
	logic [IDX_W-1:0]    idx_q;
	logic [IDX_W-1:0]    dvd_q;
	logic [BI_W-1:0]     rem_q;
	logic [CW-1:0]       lim_q;
	logic [WA-1:0]       iw_q;
	logic [BN_W-1:0]     ibase_q;
	logic [WA-1:0]       cw_s1;
	logic [BN_W-1:0]     cbase_s1;
	status_t             res_status_q;
	logic [IDX_W-1:0]    res_bit_q;
	status_t             status_q;
	logic [IDX_W-1:0]    bit_number_q;
	logic [CNT_W-1:0]    zones_q;

	logic [SIZE_W-1:0]   zc1;
	logic [SIZE_W-1:0]   fdz;
	logic [SIZE_W-1:0]   raw_size;
	logic [CW-1:0]       msz;
	logic [IDX_W-1:0]    eidx;
	logic                q_in_store;
	logic [XW-1:0]       base_x;
	logic [XW-1:0]       bit_x;
	logic                issue;
	logic                hit;
	logic                miss_last;
	logic                target_set;
	logic                load;

	always_comb begin
		zc1 = SIZE_W'(cfg.zone_count) + SIZE_W'(1);
		fdz = SIZE_W'(cfg.first_data_zone);
		if (sel_q == 1'b0) begin
			raw_size = SIZE_W'(cfg.inode_count) + SIZE_W'(1);
		end else if (fdz > zc1) begin
			raw_size = '0;
		end else begin
			raw_size = zc1 - fdz;
		end
		msz = (CW'(raw_size) > STORE_BITS) ? STORE_BITS : CW'(raw_size);
		eidx = (req_q == REQ_ALLOC && CW'(idx_q) >= msz) ? '0 : idx_q;
	end

	assign q_in_store = {1'b0, dvd_q} < MW_L;
	assign base_x     = XW'(idx_q) - XW'(rem_q);
	assign bit_x      = XW'(ws_bit);

	assign issue      = (state_q == S_SCAN) && (icnt_q != ICNT_END);
	assign hit        = (state_q == S_SCAN) && cv_s1 && ws.has_clear && ws.in_range;
	assign miss_last  = (state_q == S_SCAN) && cv_s1 && !(ws.has_clear && ws.in_range)
		&& (icnt_q == ICNT_END);
	assign target_set = ram_rdata[rem_q];
	assign load       = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = {sel_q, cw_s1};
		ram_wdata = ws_word;
		ram_raddr = (state_q == S_SCAN) ? {sel_q, iw_q} : {sel_q, dvd_q[WA-1:0]};
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_SCAN: begin
				ram_we = hit;
			end
			S_FREE_CHK: begin
				ram_we    = target_set;
				ram_waddr = {sel_q, dvd_q[WA-1:0]};
				ram_wdata = ram_rdata & ~(WORD_BITS'(1) << rem_q);
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			icnt_q      <= '0;
			cv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			zcnt_q      <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= cfg.read_only ? S_DONE : S_PREP;
					end
				end
				S_PREP: begin
					state_q <= S_ROUTE;
				end
				S_ROUTE: begin
					icnt_q <= '0;
					cv_s1  <= 1'b0;
					if (req_q == REQ_ALLOC) begin
						state_q <= S_SCAN;
					end else if (q_in_store) begin
						state_q <= S_FREE_RD;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SCAN: begin
					cv_s1 <= issue;
					if (issue) begin
						icnt_q <= icnt_q + 1'b1;
					end
					if (hit) begin
						if (sel_q && zcnt_q != '1) begin
							zcnt_q <= zcnt_q + 1'b1;
						end
						state_q <= S_DONE;
					end else if (miss_last) begin
						state_q <= S_DONE;
					end
				end
				S_FREE_RD: begin
					state_q <= S_FREE_CHK;
				end
				S_FREE_CHK: begin
					if (target_set && sel_q && zcnt_q != '0) begin
						zcnt_q <= zcnt_q - 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					req_q        <= req_type;
					sel_q        <= map_select;
					idx_q        <= bit_index;
					res_status_q <= ST_RO;
					res_bit_q    <= '0;
				end
			end
			S_PREP: begin
				lim_q <= msz;
				idx_q <= eidx;
				dvd_q <= eidx >> BI_W;
				rem_q <= eidx[BI_W-1:0];
			end
			S_ROUTE: begin
				iw_q         <= dvd_q[WA-1:0];
				ibase_q      <= base_x[BN_W-1:0];
				res_status_q <= ST_FREE_ERR;
				res_bit_q    <= '0;
			end
			S_SCAN: begin
				if (issue) begin
					cw_s1    <= iw_q;
					cbase_s1 <= ibase_q;
					if (iw_q == LAST_WORD) begin
						iw_q    <= '0;
						ibase_q <= '0;
					end else begin
						iw_q    <= iw_q + 1'b1;
						ibase_q <= ibase_q + BN_W'(WORD_BITS);
					end
				end
				if (hit) begin
					res_status_q <= ST_OK;
					res_bit_q    <= bit_x[IDX_W-1:0];
				end else if (miss_last) begin
					res_status_q <= ST_FULL;
					res_bit_q    <= '0;
				end
			end
			S_FREE_CHK: begin
				res_status_q <= target_set ? ST_OK : ST_FREE_ERR;
			end
			S_DONE: begin
				if (load) begin
					status_q     <= res_status_q;
					bit_number_q <= res_bit_q;
					zones_q      <= zcnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall     = state_q != S_IDLE;
	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign bit_number   = bit_number_q;
	assign zones_in_use = zones_q;
	assign scan_base    = cbase_s1;
	assign scan_limit   = lim_q;

endmodule

[design/bsa_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bsa_checker
// Port-level assertions for the bitmap slot allocator, bound to the top level.
// ---------------------------------------------------------------------------
module bsa_checker
	import bsa_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  req_type,
	input logic                  map_select,
	input logic [IDX_W-1:0]      bit_index,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic [1:0]            status,
	input logic [IDX_W-1:0]      bit_number,
	input logic [CNT_W-1:0]      zones_in_use,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(bit_number)
			&& $stable(zones_in_use))
		else $error("result changed while stalled");

	a_no_bit_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != 2'(ST_OK)) |-> bit_number == '0)
		else $error("bit number set on a failed or free transaction");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request accepted while a transaction is in progress");

	a_clear_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> in_stall)
		else $error("request channel open before the bitmap clear pass");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);
